### rtl/core/sfp_pkg.sv
package sfp_pkg;

  // djb2 seed and the shred length after reset
  localparam logic [31:0] HASH_SEED          = 32'd5381;
  localparam logic [7:0]  SHRED_LENGTH_RESET = 8'd16;
  localparam int unsigned FINGERPRINT_BYTES_DEFAULT = 1024;

  // fixed field widths of the item
  localparam int unsigned READ_INDEX_W = 10;
  localparam int unsigned BIT_INDEX_W  = 13;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_SHRED = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_RMW   = 4'b0100,
    ST_READ  = 4'b1000
  } state_t;

endpackage

### rtl/core/shred_hash_fingerprint_top.sv
// shred fingerprint with a single djb2 hash. each item carries a command in
// s_tuser: clear zeroes the fingerprint, shred hashes data_byte into a running
// 32-bit djb2 hash (seed 5381, hash*33+byte) and, once shred_length bytes have
// been taken (0 means 256), sets one bit of the fingerprint memory and reports
// its index, read returns one fingerprint byte (0 beyond the memory). every
// item gives exactly one result item. items are worked one at a time: a plain
// shred byte or an unused command is answered from the accepting state, a
// shred-completing byte or a read passes through ST_RMW or ST_READ because of
// the read-modify-write on the synchronous fingerprint ram (registered read data).
// after reset and after every clear the fingerprint ram is swept to zero, one
// byte a cycle, during which s_tready stays low; shred_length writes are taken
// at any time on the configuration channel.
module shred_hash_fingerprint_top
  import sfp_pkg::*;
#(
  parameter int unsigned FINGERPRINT_BYTES = FINGERPRINT_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: shred_length
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // data_byte [7:0], read_index [17:8], zero pad
  input  logic [1:0]  s_tuser,   // command [1:0]
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // bit_index [12:0], read_data [20:13], zero pad
  output logic        m_tuser    // shred_done [0]
);

  // address width of the fingerprint ram and width of a bit index into it
  localparam int unsigned AW    = (FINGERPRINT_BYTES > 1) ? $clog2(FINGERPRINT_BYTES) : 1;
  localparam int unsigned NBITS = 8 * FINGERPRINT_BYTES;
  localparam int unsigned BW    = $clog2(NBITS);
  localparam int unsigned IW    = (AW > READ_INDEX_W) ? AW : READ_INDEX_W;

  state_t state;

  // configuration and hash state
  logic [7:0]  shred_length;
  logic [31:0] running_hash;
  logic [7:0]  bytes_in_shred;

  // sweep pointer and pending ram work
  logic [AW-1:0] clr_addr;
  logic [AW-1:0] pend_addr;
  logic [2:0]    pend_bit;
  logic [BIT_INDEX_W-1:0] pend_index;
  logic          rd_in_range;

  // output register
  logic                   out_done;
  logic [BIT_INDEX_W-1:0] out_bit;
  logic [7:0]             out_rdata;

  // ram ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  // unpacked input fields
  cmd_t                    in_cmd;
  logic [7:0]              in_byte;
  logic [READ_INDEX_W-1:0] in_rindex;
  logic                    in_accept;

  // hash datapath
  logic [31:0]   hash_next;
  logic [8:0]    count_next;
  logic [8:0]    len_eff;
  logic          shred_end;
  logic [BW-1:0] idx;
  logic [AW-1:0] rd_addr;
  logic          rd_ok;

  assign in_cmd    = cmd_t'(s_tuser);
  assign in_byte   = s_tdata[7:0];
  assign in_rindex = s_tdata[17:8];

  assign cfg_ready = 1'b1;
  // one item at a time; the result slot must be free or emptying
  assign s_tready  = (state == ST_IDLE) && (!m_tvalid || m_tready);
  assign in_accept = s_tvalid && s_tready;

  // hash*33 + byte, wrapping at 32 bits
  assign hash_next  = (running_hash << 5) + running_hash + 32'(in_byte);
  assign count_next = {1'b0, bytes_in_shred} + 9'd1;
  assign len_eff    = (shred_length == 8'd0) ? 9'd256 : {1'b0, shred_length};
  assign shred_end  = (count_next >= len_eff);

  // hash masked by the bit count less one, which always lands inside the fingerprint
  assign idx = BW'(hash_next & 32'(NBITS - 1));

  // read address, with out-of-range reads answered by zero
  assign rd_addr = AW'(IW'(in_rindex));
  assign rd_ok   = (32'(in_rindex) < FINGERPRINT_BYTES);

  // ram control: sweep or write back on the write port, item address on read
  assign ram_we    = (state == ST_CLEAR) || (state == ST_RMW);
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : pend_addr;
  assign ram_wdata = (state == ST_CLEAR) ? 8'd0 : (ram_rdata | (8'd1 << pend_bit));
  assign ram_re    = in_accept;
  assign ram_raddr = (in_cmd == CMD_READ) ? rd_addr : AW'(idx >> 3);

  sfp_ram #(
    .WIDTH(8),
    .DEPTH(FINGERPRINT_BYTES)
  ) u_fp_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      shred_length <= SHRED_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      shred_length <= cfg_data;
    end
  end

  // control, hash state and sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      running_hash   <= HASH_SEED;
      bytes_in_shred <= 8'd0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          if (clr_addr == AW'(FINGERPRINT_BYTES - 1)) begin
            state <= ST_IDLE;
          end
          clr_addr <= clr_addr + AW'(1);
        end
        ST_IDLE: begin
          if (in_accept) begin
            unique case (in_cmd)
              CMD_CLEAR: begin
                // only the fingerprint is cleared, a partial shred goes on
                state    <= ST_CLEAR;
                clr_addr <= '0;
              end
              CMD_SHRED: begin
                if (shred_end) begin
                  state          <= ST_RMW;
                  running_hash   <= HASH_SEED;
                  bytes_in_shred <= 8'd0;
                end else begin
                  running_hash   <= hash_next;
                  bytes_in_shred <= count_next[7:0];
                end
              end
              CMD_READ: begin
                state <= ST_READ;
              end
              default: begin
              end
            endcase
          end
        end
        ST_RMW: begin
          state <= ST_IDLE;
        end
        ST_READ: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // pending work captured at acceptance
  always_ff @(posedge clk) begin
    if (in_accept) begin
      pend_addr   <= AW'(idx >> 3);
      pend_bit    <= idx[2:0];
      pend_index  <= BIT_INDEX_W'(idx);
      rd_in_range <= rd_ok;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      priority if (state == ST_RMW) begin
        m_tvalid  <= 1'b1;
        out_done  <= 1'b1;
        out_bit   <= pend_index;
        out_rdata <= 8'd0;
      end else if (state == ST_READ) begin
        m_tvalid  <= 1'b1;
        out_done  <= 1'b0;
        out_bit   <= '0;
        out_rdata <= rd_in_range ? ram_rdata : 8'd0;
      end else if (in_accept && !(in_cmd == CMD_READ)
                   && !(in_cmd == CMD_SHRED && shred_end)) begin
        // clear, unused command or a byte inside a shred answers at once
        m_tvalid  <= 1'b1;
        out_done  <= 1'b0;
        out_bit   <= '0;
        out_rdata <= 8'd0;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end else begin
        // waiting result stays put
      end
    end
  end

  assign m_tdata = {3'b000, out_rdata, out_bit};
  assign m_tuser = out_done;

  // the result slot is free whenever a ram result is about to be loaded
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RMW || state == ST_READ) |-> !m_tvalid)
    else $error("result slot busy when ram result arrives");

  // an accepted clear blocks new items while the sweep runs
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_cmd == CMD_CLEAR) |=> (state == ST_CLEAR && !s_tready))
    else $error("clear sweep not started");

  // a completed shred restarts the hash
  a_hash_restart: assert property (@(posedge clk) disable iff (rst)
    (in_accept && in_cmd == CMD_SHRED && shred_end)
      |=> (running_hash == HASH_SEED && bytes_in_shred == 8'd0))
    else $error("hash not restarted after shred");

  // write-back address always lies inside the fingerprint
  a_rmw_addr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RMW) |-> (32'(pend_addr) < FINGERPRINT_BYTES))
    else $error("fingerprint write beyond the memory");

endmodule

### rtl/core/sfp_ram.sv
module sfp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sim/shred_hash_fingerprint_top_tb.sv
module shred_hash_fingerprint_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfp_pkg::*;

  localparam int unsigned FP_BYTES    = FINGERPRINT_BYTES_DEFAULT;
  localparam int unsigned FP_BITS     = FP_BYTES * 8;
  // the block ignores this command code, but it must still answer with zeros
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int          IDLE_PCT    = 38;
  // worst case: ~880 items, each a read-modify-write or a read at worst, stretched by sender gaps and
  // receiver stalls, plus a sweep of the whole fingerprint after reset and after each clear
  // (roughly a dozen); taken many times over
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          TAIL_CYCLES = 20;
  localparam int          MAX_REPORTS = 40;

  typedef struct packed {
    logic        done;
    logic [12:0] bit_idx;
    logic [7:0]  rdata;
  } fp_result_t;

  localparam fp_result_t ALL_ZERO = '0;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic [9:0] rindex;
    logic       at_last;  // read the byte holding the most recently set bit
    logic       fixed;    // expectation typed in below, else taken from the predictor
    fp_result_t want;
  } dir_row_t;

  // directed items, run at the shred length left by reset (16 bytes)
  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // fingerprint is empty after reset: both ends of the memory read zero
    '{CMD_READ,   8'h00, 10'd0,    1'b0, 1'b1, ALL_ZERO},
    '{CMD_READ,   8'h00, 10'd1023, 1'b0, 1'b1, ALL_ZERO},
    // unused command with every data and index bit set does nothing
    '{CMD_UNUSED, 8'hff, 10'd1023, 1'b0, 1'b1, ALL_ZERO},
    // one full shred of 16 bytes, data extremes and walking bits
    '{CMD_SHRED,  8'h00, 10'd0,    1'b0, 1'b0, ALL_ZERO},
    '{CMD_SHRED,  8'hff, 10'd1023, 1'b0, 1'b0, ALL_ZERO},
    '{CMD_SHRED,  8'h01, 10'd0,    1'b0, 1'b0, ALL_ZERO},
    '{CMD_SHRED,  8'h80, 10'd0,    1'b0, 1'b0, ALL_ZERO},
    '{CMD_SHRED,  8'h7f, 10'd0,    1'b0, 1'b0, ALL_ZERO},
    '{CMD_SHRED,  8'hfe, 10'd0,    1'b0, 1'b0, ALL_ZERO},
    '{CMD_SHRED,  8'h55, 10'd0,    1'b0, 1'b0, ALL_ZERO},
    '{CMD_SHRED,  8'haa, 10'd0,    1'b0, 1'b0, ALL_ZERO},
    '{CMD_SHRED,  8'h00, 10'd0,    1'b0, 1'b0, ALL_ZERO},
    '{CMD_SHRED,  8'hff, 10'd0,    1'b0, 1'b0, ALL_ZERO},
    '{CMD_SHRED,  8'h10, 10'd0,    1'b0, 1'b0, ALL_ZERO},
    '{CMD_SHRED,  8'h20, 10'd0,    1'b0, 1'b0, ALL_ZERO},
    '{CMD_SHRED,  8'h40, 10'd0,    1'b0, 1'b0, ALL_ZERO},
    '{CMD_SHRED,  8'h08, 10'd0,    1'b0, 1'b0, ALL_ZERO},
    '{CMD_SHRED,  8'h04, 10'd0,    1'b0, 1'b0, ALL_ZERO},
    '{CMD_SHRED,  8'h02, 10'd0,    1'b0, 1'b0, ALL_ZERO},
    // the bit just set must show up
    '{CMD_READ,   8'h00, 10'd0,    1'b1, 1'b0, ALL_ZERO},
    // clear, then the same byte reads zero
    '{CMD_CLEAR,  8'hff, 10'd1023, 1'b0, 1'b1, ALL_ZERO},
    '{CMD_READ,   8'h00, 10'd0,    1'b1, 1'b1, ALL_ZERO},
    '{CMD_UNUSED, 8'h00, 10'd0,    1'b0, 1'b1, ALL_ZERO},
    // hashing carries on after a clear
    '{CMD_SHRED,  8'hff, 10'd0,    1'b0, 1'b0, ALL_ZERO},
    '{CMD_READ,   8'h00, 10'd341,  1'b0, 1'b0, ALL_ZERO}
  };

  // random phases: shred length and item count; length 0 stands for 256 bytes.
  // lengths change while a shred is part done, so a shorter length can be met
  // by the very next byte
  localparam int PHASES     = 8;
  localparam int CALM_PHASE = 2;
  localparam logic [7:0] PHASE_LEN [PHASES] = '{
    8'd1, 8'd255, 8'd2, 8'd0, 8'd5, 8'd16, 8'd3, 8'd128
  };
  localparam int PHASE_ITEMS [PHASES] = '{100, 290, 90, 60, 90, 90, 80, 50};

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data  = 8'd0;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata   = 24'd0;   // data_byte [7:0], read_index [17:8], zero pad
  logic [1:0]  s_tuser   = 2'd0;    // command [1:0]
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [23:0] m_tdata;             // bit_index [12:0], read_data [20:13], zero pad
  logic        m_tuser;             // shred_done [0]

  // no idling on either side while set
  logic calm = 1'b0;

  // predictor state: a mirror of the fingerprint, the running hash, the fill
  // count of the shred in progress and the shred length last written
  logic [7:0]  fp_mirror [FP_BYTES];
  logic [31:0] hash_acc;
  int unsigned shred_fill;
  logic [7:0]  shred_len;
  int unsigned last_bit;
  int unsigned set_bits [$];        // bits set since the last clear, for useful reads

  fp_result_t  awaited_results [$];
  fp_result_t  oldest;
  int          mismatch_count = 0;
  int          cycle_count    = 0;

  shred_hash_fingerprint_top #(
    .FINGERPRINT_BYTES(FP_BYTES)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // expected result of one item; updates the mirrored state
  function automatic fp_result_t fingerprint_step(input logic [1:0] cmd,
                                                  input logic [7:0] data,
                                                  input logic [9:0] rindex);
    fp_result_t  res;
    int unsigned need;
    int unsigned idx;
    res = ALL_ZERO;
    case (cmd)
      CMD_CLEAR: begin
        // only the fingerprint goes; hash and fill count carry on
        foreach (fp_mirror[i]) fp_mirror[i] = 8'h00;
        set_bits.delete();
      end
      CMD_SHRED: begin
        need = (shred_len == 8'd0) ? 32'd256 : {24'd0, shred_len};
        hash_acc = hash_acc * 32'd33 + {24'd0, data};
        if (shred_fill + 1 >= need) begin
          idx = (hash_acc & (FP_BITS - 1)) % FP_BITS;
          fp_mirror[idx / 8][idx % 8] = 1'b1;
          res.done    = 1'b1;
          res.bit_idx = idx[12:0];
          last_bit    = idx;
          set_bits.push_back(idx);
          hash_acc    = HASH_SEED;
          shred_fill  = 0;
        end else begin
          shred_fill++;
        end
      end
      CMD_READ: begin
        if (rindex < FP_BYTES) res.rdata = fp_mirror[rindex];
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (mismatch_count < MAX_REPORTS)
      $display("mismatch at cycle %0d: %s, got %0d, expected %0d",
               cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // drive one item from a falling edge, hold it until taken, and queue its
  // expectation at the accepting edge; returns on the next falling edge
  task automatic send_item(input logic [1:0] cmd, input logic [7:0] data,
                           input logic [9:0] rindex, input logic fixed,
                           input fp_result_t want);
    fp_result_t predicted;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, rindex, data};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    predicted = fingerprint_step(cmd, data, rindex);
    awaited_results.push_back(fixed ? want : predicted);
    @(negedge clk);
  endtask

  // sender holds off until every awaited result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_shred_length(input logic [7:0] len);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    shred_len = len;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver stalls at random, never while calm
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // result checker, in order against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing awaited", 32'({m_tuser, m_tdata}), 0);
      end else begin
        oldest = awaited_results.pop_front();
        if (m_tuser !== oldest.done)
          report_mismatch("shred_done", 32'(m_tuser), 32'(oldest.done));
        if (m_tdata[12:0] !== oldest.bit_idx)
          report_mismatch("bit_index", 32'(m_tdata[12:0]), 32'(oldest.bit_idx));
        if (m_tdata[20:13] !== oldest.rdata)
          report_mismatch("read_data", 32'(m_tdata[20:13]), 32'(oldest.rdata));
      end
    end
  end

  // timeout
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[shred_hash_fingerprint_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [1:0]  cmd;
    logic [7:0]  data;
    logic [9:0]  rindex;
    int unsigned roll;

    foreach (fp_mirror[i]) fp_mirror[i] = 8'h00;
    hash_acc   = HASH_SEED;
    shred_fill = 0;
    shred_len  = SHRED_LENGTH_RESET;
    last_bit   = 0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part; the post-reset sweep just shows up as s_tready low
    for (int i = 0; i < DIR_ROWS; i++) begin
      rindex = DIRECTED[i].at_last ? 10'(last_bit / 8) : DIRECTED[i].rindex;
      send_item(DIRECTED[i].cmd, DIRECTED[i].data, rindex, DIRECTED[i].fixed,
                DIRECTED[i].want);
    end

    // random part: mostly shred bytes, some reads aimed at set bits, rare clears
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_shred_length(PHASE_LEN[p]);
      calm = (p == CALM_PHASE);
      for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
        roll = $urandom_range(0, 999);
        data = 8'($urandom);
        if ($urandom_range(0, 15) == 0)
          data = ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
        rindex = 10'($urandom);
        if (roll < 8) begin
          cmd = CMD_CLEAR;
        end else if (roll < 70) begin
          cmd = CMD_UNUSED;
        end else if (roll < 180) begin
          cmd = CMD_READ;
          if (set_bits.size() != 0 && $urandom_range(0, 99) < 60)
            rindex = 10'(set_bits[$urandom_range(0, set_bits.size() - 1)] / 8);
        end else begin
          cmd = CMD_SHRED;
        end
        send_item(cmd, data, rindex, 1'b0, ALL_ZERO);
      end
      calm = 1'b0;
    end

    // wait for the last results, then a short tail for anything stray
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (awaited_results.size() != 0)
      report_mismatch("results never delivered", 32'(awaited_results.size()), 0);

    if (mismatch_count == 0) begin
      $display("[shred_hash_fingerprint_top] OK");
    end else begin
      $display("[shred_hash_fingerprint_top] ERROR");
    end
    $finish;
  end

endmodule
